// File: rtl/fasta_sequence_filter_unit_macros.svh
// Assertion helpers for the FASTA filter checker
`ifndef FASTA_SEQUENCE_FILTER_UNIT_MACROS_SVH
`define FASTA_SEQUENCE_FILTER_UNIT_MACROS_SVH

// same-cycle implication, silent during reset
`define FSF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fsf assertion failed");

// next-cycle implication, silent during reset
`define FSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fsf assertion failed");

`endif

// File: rtl/fsf_pkg.sv
package fsf_pkg;

    localparam int MAX_IDENT_LEN_DEF = 64;
    localparam int POS_W             = 32;

    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [1:0] KIND_IDENT   = 2'd0;
    localparam logic [1:0] KIND_RESIDUE = 2'd1;
    localparam logic [1:0] KIND_SEP     = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NORECORD = 2'd1;
    localparam logic [1:0] ST_INHEADER = 2'd2;

    localparam logic REG_HDR_OPEN = 1'b0;

    typedef enum logic [5:0] {
        PH_SEEK     = 6'b000001,
        PH_LEADSP   = 6'b000010,
        PH_IDENT    = 6'b000100,
        PH_SKIPLINE = 6'b001000,
        PH_BODY     = 6'b010000,
        PH_HDRSKIP  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic       emit;
        logic [1:0] kind;
        logic [1:0] status;
        t_phase     phase;
    } t_step;

endpackage

// File: rtl/fsf_if.sv
interface fsf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_input;

    modport source (output valid, output text_byte, output end_of_input, input ready);
    modport sink   (input valid, input text_byte, input end_of_input, output ready);
endinterface

interface fsf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [7:0]  symbol;
    logic [31:0] position;
    logic [1:0]  status;

    modport source (output valid, output item_kind, output symbol, output position,
                    output status, input ready);
    modport sink   (input valid, input item_kind, input symbol, input position,
                    input status, output ready);
endinterface

// File: rtl/fsf_step.sv
module fsf_step #(
    parameter int MAX_IDENT_LEN = fsf_pkg::MAX_IDENT_LEN_DEF,
    localparam int IdW = $clog2(MAX_IDENT_LEN + 1)
) (
    input  fsf_pkg::t_phase              i_phase,
    input  logic [IdW-1:0]               i_ident,
    input  logic [fsf_pkg::POS_W-1:0]    i_residue,
    input  logic                         i_hdr_open,
    input  logic [7:0]                   i_byte,
    input  logic                         i_eoi,
    output fsf_pkg::t_step               o_ctrl,
    output logic [IdW-1:0]               o_ident,
    output logic [fsf_pkg::POS_W-1:0]    o_residue,
    output logic [7:0]                   o_symbol,
    output logic [fsf_pkg::POS_W-1:0]    o_position
);

    logic [7:0] upper;
    logic       id_take;
    logic       res_sat;

    always_comb begin
        upper = i_byte;
        if (i_byte >= fsf_pkg::CH_LC_A && i_byte <= fsf_pkg::CH_LC_Z) begin
            upper = i_byte - fsf_pkg::CASE_OFS;
        end
    end

    assign id_take = (i_ident < IdW'(MAX_IDENT_LEN)) && (i_byte != fsf_pkg::CH_NL)
                     && (i_byte != fsf_pkg::CH_SPACE);
    assign res_sat = &i_residue;

    always_comb begin
        o_ctrl.emit   = 1'b0;
        o_ctrl.kind   = fsf_pkg::KIND_IDENT;
        o_ctrl.status = fsf_pkg::ST_OK;
        o_ctrl.phase  = i_phase;
        o_ident       = i_ident;
        o_residue     = i_residue;
        o_symbol      = i_byte;
        o_position    = i_residue;

        if (i_eoi) begin
            o_ctrl.emit   = 1'b1;
            o_ctrl.kind   = fsf_pkg::KIND_SUMMARY;
            o_symbol      = fsf_pkg::CH_NUL;
            o_ctrl.phase  = fsf_pkg::PH_SEEK;
            o_ident       = '0;
            o_residue     = '0;
            if (i_phase == fsf_pkg::PH_BODY) begin
                o_ctrl.status = fsf_pkg::ST_OK;
            end else if (i_phase == fsf_pkg::PH_SEEK && !i_hdr_open) begin
                o_ctrl.status = fsf_pkg::ST_NORECORD;
            end else begin
                o_ctrl.status = fsf_pkg::ST_INHEADER;
            end
        end else begin
            unique case (i_phase)
                fsf_pkg::PH_SEEK, fsf_pkg::PH_LEADSP, fsf_pkg::PH_IDENT: begin
                    if (i_phase == fsf_pkg::PH_SEEK && !i_hdr_open) begin
                        if (i_byte == fsf_pkg::CH_GT) begin
                            o_ctrl.phase = fsf_pkg::PH_LEADSP;
                        end
                    end else if (i_phase != fsf_pkg::PH_IDENT
                                 && i_byte == fsf_pkg::CH_SPACE) begin
                        o_ctrl.phase = fsf_pkg::PH_LEADSP;
                    end else if (id_take) begin
                        o_ctrl.emit  = 1'b1;
                        o_ctrl.kind  = fsf_pkg::KIND_IDENT;
                        o_ctrl.phase = fsf_pkg::PH_IDENT;
                        o_position   = fsf_pkg::POS_W'(i_ident);
                        o_ident      = i_ident + 1'b1;
                    end else begin
                        o_ctrl.phase = (i_byte == fsf_pkg::CH_NL) ? fsf_pkg::PH_BODY
                                                                  : fsf_pkg::PH_SKIPLINE;
                    end
                end
                fsf_pkg::PH_SKIPLINE, fsf_pkg::PH_HDRSKIP: begin
                    if (i_byte == fsf_pkg::CH_NL) begin
                        o_ctrl.phase = fsf_pkg::PH_BODY;
                    end
                end
                fsf_pkg::PH_BODY: begin
                    o_symbol = upper;
                    if (upper == fsf_pkg::CH_GT) begin
                        o_ctrl.emit  = 1'b1;
                        o_ctrl.kind  = fsf_pkg::KIND_SEP;
                        o_symbol     = fsf_pkg::CH_STAR;
                        o_ctrl.phase = fsf_pkg::PH_HDRSKIP;
                        o_residue    = res_sat ? i_residue : i_residue + 1'b1;
                    end else if ((upper >= fsf_pkg::CH_UC_A && upper <= fsf_pkg::CH_UC_Z)
                                 || upper == fsf_pkg::CH_STAR) begin
                        o_ctrl.emit  = 1'b1;
                        o_ctrl.kind  = fsf_pkg::KIND_RESIDUE;
                        o_residue    = res_sat ? i_residue : i_residue + 1'b1;
                    end
                end
                default: begin
                    o_ctrl.phase = fsf_pkg::PH_SEEK;
                    o_ident      = '0;
                    o_residue    = '0;
                end
            endcase
        end
    end

endmodule

// File: rtl/fasta_sequence_filter_unit.sv
// FASTA sequence filter.
// i_in carries one text byte per item (or an end-of-input marker); o_out carries
// identifier characters, upper-cased residues, '*' record separators and one
// summary item (total length and status) per end marker. Bytes that give no
// result are consumed silently.
// Timing: an accepted item sits in the input register, then its result is
// loaded into the output register, where it shows valid and can leave. One
// item is taken every cycle while o_out is not stalled; the single state update
// between the input and output registers sets that rate.
// Stalls: while o_out.ready is low a waiting result holds still; the input
// register can still fill, and i_in.ready falls once both registers are held.
// Reset (synchronous, i_rst_n low) empties both registers, returns the parser
// to seeking a header start and clears header_already_open. The register sits
// at paddr 0 on the APB port (bit 0); write it only while the block is idle.
module fasta_sequence_filter_unit #(
    parameter int MAX_IDENT_LEN = fsf_pkg::MAX_IDENT_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fsf_in_if.sink            i_in,
    fsf_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IdW = $clog2(MAX_IDENT_LEN + 1);

    logic                         r_hdr_open;
    logic                         r_in_valid;
    logic [7:0]                   r_in_byte;
    logic                         r_in_eoi;
    fsf_pkg::t_phase              r_phase;
    logic [IdW-1:0]               r_ident;
    logic [fsf_pkg::POS_W-1:0]    r_residue;
    logic                         r_out_valid;
    logic [1:0]                   r_out_kind;
    logic [7:0]                   r_out_symbol;
    logic [fsf_pkg::POS_W-1:0]    r_out_pos;
    logic [1:0]                   r_out_status;

    fsf_pkg::t_step               n_ctrl;
    logic [IdW-1:0]               n_ident;
    logic [fsf_pkg::POS_W-1:0]    n_residue;
    logic [7:0]                   n_symbol;
    logic [fsf_pkg::POS_W-1:0]    n_pos;

    logic advance;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == fsf_pkg::REG_HDR_OPEN);
    assign prdata = (paddr[2] == fsf_pkg::REG_HDR_OPEN) ? {31'd0, r_hdr_open} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_open <= 1'b0;
        end else if (cfg_wr) begin
            r_hdr_open <= pwdata[0];
        end
    end

    // input register moves on whenever the output register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.text_byte;
            r_in_eoi  <= i_in.end_of_input;
        end
    end

    fsf_step #(.MAX_IDENT_LEN(MAX_IDENT_LEN)) u_step (
        .i_phase    (r_phase),
        .i_ident    (r_ident),
        .i_residue  (r_residue),
        .i_hdr_open (r_hdr_open),
        .i_byte     (r_in_byte),
        .i_eoi      (r_in_eoi),
        .o_ctrl     (n_ctrl),
        .o_ident    (n_ident),
        .o_residue  (n_residue),
        .o_symbol   (n_symbol),
        .o_position (n_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= fsf_pkg::PH_SEEK;
            r_ident   <= '0;
            r_residue <= '0;
        end else if (advance) begin
            r_phase   <= n_ctrl.phase;
            r_ident   <= n_ident;
            r_residue <= n_residue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_ctrl.emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_ctrl.emit) begin
            r_out_kind   <= n_ctrl.kind;
            r_out_symbol <= n_symbol;
            r_out_pos    <= n_pos;
            r_out_status <= n_ctrl.status;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.item_kind = r_out_kind;
    assign o_out.symbol    = r_out_symbol;
    assign o_out.position  = r_out_pos;
    assign o_out.status    = r_out_status;

endmodule

// File: rtl/fsf_checker.sv
`include "fasta_sequence_filter_unit_macros.svh"

module fsf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_kind,
    input logic [7:0]  i_out_symbol,
    input logic [31:0] i_out_position,
    input logic [1:0]  i_out_status,
    input logic        i_pready
);

    // a stalled result must hold
    `FSF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_kind) && $stable(i_out_symbol) && $stable(i_out_position) && $stable(i_out_status))

    // only summaries carry a non-zero status
    `FSF_ASSERT_IMPLY(a_status_only_summary, i_clk, i_rst_n, i_out_valid && i_out_kind != fsf_pkg::KIND_SUMMARY, i_out_status == fsf_pkg::ST_OK)

    `FSF_ASSERT_IMPLY(a_sep_symbol, i_clk, i_rst_n, i_out_valid && i_out_kind == fsf_pkg::KIND_SEP, i_out_symbol == fsf_pkg::CH_STAR)

    `FSF_ASSERT_IMPLY(a_summary_symbol, i_clk, i_rst_n, i_out_valid && i_out_kind == fsf_pkg::KIND_SUMMARY, i_out_symbol == fsf_pkg::CH_NUL && i_out_status <= fsf_pkg::ST_INHEADER)

    `FSF_ASSERT_IMPLY(a_pready_high, i_clk, i_rst_n, 1'b1, i_pready)

endmodule

bind fasta_sequence_filter_unit fsf_checker u_fsf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_kind     (o_out.item_kind),
    .i_out_symbol   (o_out.symbol),
    .i_out_position (o_out.position),
    .i_out_status   (o_out.status),
    .i_pready       (pready)
);

// File: tb/sv/fasta_sequence_filter_unit_tb.sv
`timescale 1ns / 1ps

module fasta_sequence_filter_unit_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRESSURE_HOLD  = 400;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_RESULTS  = 100;
    localparam logic [2:0] HDR_OPEN_ADDR = 3'(4 * fsf_pkg::REG_HDR_OPEN);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  sym;
        logic [31:0] pos;
        logic [1:0]  status;
    } t_filt_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fsf_in_if  in_if ();
    fsf_out_if out_if ();

    fasta_sequence_filter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // parser state as the block should hold it
    logic             hdr_open_cfg;
    fsf_pkg::t_phase  parse_phase;
    logic [6:0]       ident_len;
    logic [31:0]      residue_len;

    t_filt_result expected_q[$];
    int           mismatches;
    int           emitting_items;
    int           idle_cycles = 0;
    int           hold_off_len;
    bit           src_quiet;
    bit           sink_quiet;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // prediction

    function automatic bit take_ident_char(input logic [7:0] c, output t_filt_result r);
        r = '0;
        if (int'(ident_len) < fsf_pkg::MAX_IDENT_LEN_DEF && c != fsf_pkg::CH_NL
            && c != fsf_pkg::CH_SPACE) begin
            r.kind = fsf_pkg::KIND_IDENT;
            r.sym  = c;
            r.pos  = 32'(ident_len);
            r.status = fsf_pkg::ST_OK;
            ident_len   = ident_len + 7'd1;
            parse_phase = fsf_pkg::PH_IDENT;
            return 1'b1;
        end
        parse_phase = (c == fsf_pkg::CH_NL) ? fsf_pkg::PH_BODY : fsf_pkg::PH_SKIPLINE;
        return 1'b0;
    endfunction

    function automatic logic [31:0] next_residue_pos();
        logic [31:0] p;
        p = residue_len;
        if (residue_len != '1)
            residue_len = residue_len + 32'd1;
        return p;
    endfunction

    function automatic bit filter_byte(input logic [7:0] b, input logic eoi,
                                       output t_filt_result r);
        logic [7:0] c;
        r = '0;
        c = b;
        if (eoi) begin
            r.kind = fsf_pkg::KIND_SUMMARY;
            r.sym  = fsf_pkg::CH_NUL;
            r.pos  = residue_len;
            if (parse_phase == fsf_pkg::PH_BODY)
                r.status = fsf_pkg::ST_OK;
            else if (parse_phase == fsf_pkg::PH_SEEK && !hdr_open_cfg)
                r.status = fsf_pkg::ST_NORECORD;
            else
                r.status = fsf_pkg::ST_INHEADER;
            parse_phase = fsf_pkg::PH_SEEK;
            ident_len   = '0;
            residue_len = '0;
            return 1'b1;
        end
        case (parse_phase)
            fsf_pkg::PH_SEEK: begin
                if (!hdr_open_cfg) begin
                    if (c == fsf_pkg::CH_GT)
                        parse_phase = fsf_pkg::PH_LEADSP;
                    return 1'b0;
                end
                if (c == fsf_pkg::CH_SPACE) begin
                    parse_phase = fsf_pkg::PH_LEADSP;
                    return 1'b0;
                end
                return take_ident_char(c, r);
            end
            fsf_pkg::PH_LEADSP: begin
                if (c == fsf_pkg::CH_SPACE)
                    return 1'b0;
                return take_ident_char(c, r);
            end
            fsf_pkg::PH_IDENT: return take_ident_char(c, r);
            fsf_pkg::PH_SKIPLINE, fsf_pkg::PH_HDRSKIP: begin
                if (c == fsf_pkg::CH_NL)
                    parse_phase = fsf_pkg::PH_BODY;
                return 1'b0;
            end
            fsf_pkg::PH_BODY: begin
                if (c >= fsf_pkg::CH_LC_A && c <= fsf_pkg::CH_LC_Z)
                    c = c - fsf_pkg::CASE_OFS;
                if (c == fsf_pkg::CH_GT) begin
                    parse_phase = fsf_pkg::PH_HDRSKIP;
                    r.kind = fsf_pkg::KIND_SEP;
                    r.sym  = fsf_pkg::CH_STAR;
                    r.pos  = next_residue_pos();
                    return 1'b1;
                end
                if ((c >= fsf_pkg::CH_UC_A && c <= fsf_pkg::CH_UC_Z)
                    || c == fsf_pkg::CH_STAR) begin
                    r.kind = fsf_pkg::KIND_RESIDUE;
                    r.sym  = c;
                    r.pos  = next_residue_pos();
                    return 1'b1;
                end
                return 1'b0;
            end
            default: begin
                parse_phase = fsf_pkg::PH_SEEK;
                ident_len   = '0;
                residue_len = '0;
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // checking

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_filt_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing pending", '0, out_if.position);
            end else begin
                want = expected_q.pop_front();
                if (out_if.item_kind !== want.kind)
                    report_mismatch("item_kind", want.kind, out_if.item_kind);
                if (out_if.symbol !== want.sym)
                    report_mismatch("symbol", want.sym, out_if.symbol);
                if (out_if.position !== want.pos)
                    report_mismatch("position", want.pos, out_if.position);
                if (out_if.status !== want.status)
                    report_mismatch("status", want.status, out_if.status);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off on request

    function automatic int pick_stall_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(15, 50);
        return $urandom_range(1, 3);
    endfunction

    initial begin : sink_side
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_len != 0) begin
                stall_left   = hold_off_len;
                hold_off_len = 0;
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else if (!sink_quiet && $urandom_range(0, 7) == 0) begin
                out_if.ready <= 1'b0;
                stall_left = pick_stall_len() - 1;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender and register access

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // valid stays high between back-to-back items
    task automatic send_item(input logic [7:0] b, input logic eoi);
        int gap;
        t_filt_result res;
        gap = src_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.text_byte    <= b;
        in_if.end_of_input <= eoi;
        do @(posedge i_clk); while (!in_if.ready);
        if (filter_byte(b, eoi, res)) begin
            expected_q.push_back(res);
            emitting_items++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // the byte travelling with an end marker is don't-care, so randomise it
    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // stop offering, let every pending result out, then cover the pipeline
    task automatic settle();
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_header_open(input logic v);
        logic [31:0] wdata;
        settle();
        wdata    = $urandom();
        wdata[0] = v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= HDR_OPEN_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        hdr_open_cfg = v;
    endtask

    // ------------------------------------------------------------------
    // random FASTA content

    function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
        return c;
    endfunction

    function automatic logic [7:0] ident_char();
        if ($urandom_range(0, 4) == 0)
            return byte_except(fsf_pkg::CH_SPACE, fsf_pkg::CH_NL);
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    function automatic logic [7:0] body_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'($urandom_range(fsf_pkg::CH_UC_A, fsf_pkg::CH_UC_Z));
        if (r < 65)
            return 8'($urandom_range(fsf_pkg::CH_LC_A, fsf_pkg::CH_LC_Z));
        if (r < 70)
            return fsf_pkg::CH_STAR;
        if (r < 75)
            return fsf_pkg::CH_SPACE;
        return byte_except(fsf_pkg::CH_GT, fsf_pkg::CH_GT);
    endfunction

    task automatic send_body();
        repeat ($urandom_range(0, 3)) begin
            repeat ($urandom_range(0, 30)) send_item(body_char(), 1'b0);
            send_item(fsf_pkg::CH_NL, 1'b0);
        end
    endtask

    // one file: optional junk, first header with identifier, records, end marker;
    // a minority are pure noise or stop inside a header
    task automatic send_fasta_file();
        int id_chars;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20)) send_item(8'($urandom_range(0, 255)), 1'b0);
            send_end();
            return;
        end
        if (!hdr_open_cfg) begin
            repeat ($urandom_range(0, 3))
                send_item(byte_except(fsf_pkg::CH_GT, fsf_pkg::CH_GT), 1'b0);
            send_item(fsf_pkg::CH_GT, 1'b0);
        end
        repeat ($urandom_range(0, 2)) send_item(fsf_pkg::CH_SPACE, 1'b0);
        id_chars = ($urandom_range(0, 6) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 10);
        repeat (id_chars) send_item(ident_char(), 1'b0);
        if ($urandom_range(0, 1) == 1) begin
            send_item(fsf_pkg::CH_SPACE, 1'b0);
            repeat ($urandom_range(0, 8))
                send_item(byte_except(fsf_pkg::CH_NL, fsf_pkg::CH_NL), 1'b0);
        end
        if ($urandom_range(0, 12) == 0) begin
            send_end();
            return;
        end
        send_item(fsf_pkg::CH_NL, 1'b0);
        send_body();
        repeat ($urandom_range(0, 3)) begin
            send_item(fsf_pkg::CH_GT, 1'b0);
            repeat ($urandom_range(0, 6))
                send_item(byte_except(fsf_pkg::CH_NL, fsf_pkg::CH_NL), 1'b0);
            if ($urandom_range(0, 15) == 0) begin
                send_end();
                return;
            end
            send_item(fsf_pkg::CH_NL, 1'b0);
            send_body();
        end
        send_end();
    endtask

    // ------------------------------------------------------------------
    // tests

    // junk before '>', leading spaces, short identifier, rest of header line,
    // mixed case, '*', dropped bytes, separator, end in body / seek / header
    task automatic test_directed_records();
        send_text("q> Id z\naZ*~");
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h80, 1'b0);
        send_text(">h\nm");
        send_end();
        send_end();
        send_text(">x");
        send_end();
    endtask

    // open header: end while seeking, first byte taken as identifier;
    // register changes while parked in the body have no effect
    task automatic test_header_open_config();
        set_header_open(1'b1);
        send_end();
        send_text(" Q\ng");
        send_end();
        send_text("W\nk");
        send_end();
        set_header_open(1'b0);
        send_text(">r\nc");
        set_header_open(1'b1);
        send_text("t");
        send_end();
        set_header_open(1'b0);
    endtask

    // receiver holds off long enough for both block registers to fill
    task automatic test_backpressure();
        settle();
        src_quiet = 1'b1;
        send_text(">p\n");
        hold_off_len = PRESSURE_HOLD;
        repeat (40) send_item(8'($urandom_range(fsf_pkg::CH_UC_A, fsf_pkg::CH_UC_Z)), 1'b0);
        send_end();
        src_quiet = 1'b0;
    endtask

    task automatic test_random_streams();
        int goal;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 2)
                set_header_open(p[0]);
            else
                set_header_open($urandom_range(0, 1));
            src_quiet  = (p == 2);
            sink_quiet = (p == 2) || (p == 4);
            goal = emitting_items + PHASE_RESULTS;
            while (emitting_items < goal)
                send_fasta_file();
        end
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
    endtask

    initial begin
        in_if.valid        <= 1'b0;
        in_if.text_byte    <= 8'h00;
        in_if.end_of_input <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        hdr_open_cfg   = 1'b0;
        parse_phase    = fsf_pkg::PH_SEEK;
        ident_len      = '0;
        residue_len    = '0;
        mismatches     = 0;
        emitting_items = 0;
        hold_off_len   = 0;
        src_quiet      = 1'b0;
        sink_quiet     = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_records();
        test_header_open_config();
        test_backpressure();
        test_random_streams();

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
